// ===== sv/lkvt_pkg.sv =====
// ============================================================================
// lkvt_pkg
// Shared constants and controller/datapath interface types for the linear
// key/value table.
// ============================================================================
package lkvt_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 5;

    localparam logic [OP_W-1:0] OP_SET    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic                load;
        logic                scan;
        logic                rd_last;
        logic                wr_slot_val;
        logic                wr_append;
        logic                wr_move;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                st_load;
        logic [STATUS_W-1:0] st_code;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic            cnt_zero;
        logic            full;
        logic            match;
        logic            cmp_last;
        logic            hit;
        logic            slot_last;
        logic            out_free;
        logic [OP_W-1:0] op;
    } t_sts;

endpackage

// ===== sv/lkvt_ram.sv =====
// ============================================================================
// lkvt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module lkvt_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lkvt_ctrl.sv =====
// ============================================================================
// lkvt_ctrl
// Request sequencer: accept, scan, decide, optional entry move, result.
// ============================================================================
module lkvt_ctrl
    import lkvt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = i_sts.cnt_zero ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                w_cmd.scan = 1'b1;
                if (i_sts.match || i_sts.cmp_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                w_cmd.st_load = 1'b1;
                w_cmd.st_code = ST_DONE;
                n_state       = S_DONE;
                case (i_sts.op)
                    OP_SET: begin
                        if (i_sts.hit) begin
                            w_cmd.wr_slot_val = 1'b1;
                        end else if (!i_sts.full) begin
                            w_cmd.wr_append = 1'b1;
                            w_cmd.cnt_inc   = 1'b1;
                        end else begin
                            w_cmd.st_code = ST_FULL;
                        end
                    end
                    OP_GET: begin
                        if (!i_sts.hit) begin
                            w_cmd.st_code = ST_ABSENT;
                        end
                    end
                    OP_REMOVE: begin
                        if (!i_sts.hit) begin
                            w_cmd.st_code = ST_ABSENT;
                        end else if (i_sts.slot_last) begin
                            w_cmd.cnt_dec = 1'b1;
                        end else begin
                            w_cmd.rd_last = 1'b1;
                            n_state       = S_MOVE;
                        end
                    end
                    default: begin
                        w_cmd.st_code = ST_DONE;
                    end
                endcase
            end
            S_MOVE: begin
                w_cmd.wr_move = 1'b1;
                w_cmd.cnt_dec = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = w_cmd;

endmodule

// ===== sv/lkvt_dpath.sv =====
// ============================================================================
// lkvt_dpath
// Request registers, entry count, key/value RAMs, scan compare and result
// register.
// ============================================================================
module lkvt_dpath
    import lkvt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [OP_W-1:0]     i_op,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [VAL_W-1:0]    i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [VAL_W-1:0]    o_read_value,
    output logic [USED_W-1:0]   o_entries_used
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [OP_W-1:0]     r_op;
    logic [KEY_W-1:0]    r_key;
    logic [VAL_W-1:0]    r_value;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_addr;
    logic                r_cmp_vld;
    logic [AW-1:0]       r_cmp_idx;
    logic                r_hit;
    logic [AW-1:0]       r_slot;
    logic [VAL_W-1:0]    r_rd_val;
    logic [STATUS_W-1:0] r_status;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VAL_W-1:0]    r_out_value;
    logic [USED_W-1:0]   r_out_used;

    logic [CW-1:0]        w_last;
    logic                 w_issue;
    logic                 w_match;
    logic [AW-1:0]        w_rd_addr;
    logic [KEY_W-1:0]     w_key_rdata;
    logic [VAL_W-1:0]     w_val_rdata;
    logic                 w_key_we;
    logic                 w_val_we;
    logic [AW-1:0]        w_wr_addr;
    logic [KEY_W-1:0]     w_key_wdata;
    logic [VAL_W-1:0]     w_val_wdata;
    logic [CW+USED_W-1:0] w_cnt_ext;

    assign w_last    = r_count - CW'(1);
    assign w_issue   = (r_addr < r_count);
    assign w_match   = r_cmp_vld && (w_key_rdata == r_key);
    assign w_rd_addr = i_cmd.rd_last ? w_last[AW-1:0] : r_addr[AW-1:0];

    assign w_key_we    = i_cmd.wr_append | i_cmd.wr_move;
    assign w_val_we    = i_cmd.wr_append | i_cmd.wr_move | i_cmd.wr_slot_val;
    assign w_wr_addr   = i_cmd.wr_append ? r_count[AW-1:0] : r_slot;
    assign w_key_wdata = i_cmd.wr_move ? w_key_rdata : r_key;
    assign w_val_wdata = i_cmd.wr_move ? w_val_rdata : r_value;

    lkvt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_wr_addr),
        .i_wdata (w_key_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_key_rdata)
    );

    lkvt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_wr_addr),
        .i_wdata (w_val_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_val_rdata)
    );

    // request and scan payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
            r_addr  <= '0;
        end else if (i_cmd.scan) begin
            r_addr    <= r_addr + CW'(w_issue);
            r_cmp_idx <= r_addr[AW-1:0];
            if (w_match) begin
                r_slot   <= r_cmp_idx;
                r_rd_val <= w_val_rdata;
            end
        end
        if (i_cmd.st_load) begin
            r_status <= i_cmd.st_code;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_value  <= ((r_op == OP_GET) && r_hit) ? r_rd_val : '0;
            r_out_used   <= w_cnt_ext[USED_W-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= w_issue;
                if (w_match) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= w_last;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_cnt_ext = (CW + USED_W)'(r_count);

    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.full      = (r_count == CW'(ENTRIES));
    assign o_sts.match     = w_match;
    assign o_sts.cmp_last  = r_cmp_vld && (CW'(r_cmp_idx) == w_last);
    assign o_sts.hit       = r_hit;
    assign o_sts.slot_last = (CW'(r_slot) == w_last);
    assign o_sts.out_free  = !r_out_valid || i_ready;
    assign o_sts.op        = r_op;

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_read_value   = r_out_value;
    assign o_entries_used = r_out_used;

endmodule

// ===== sv/linear_key_value_table_top.sv =====
// ============================================================================
// linear_key_value_table_top
// Unordered key/value table with linear search and swap-and-pop remove.
// A request scans the used entries in order; a hit ends the key RAM scan early,
//   and a remove that moves the last entry into the hole adds a move step.
// One request at a time: a new request is accepted only after its result is
//   loaded into the result register; the scan does one key RAM read per cycle.
// Reset clears the entry count and the result valid flag; RAM contents are
//   left undefined and are never used beyond the count.
// ============================================================================
module linear_key_value_table_top
    import lkvt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [VAL_W-1:0]    i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [VAL_W-1:0]    o_read_value,
    output logic [USED_W-1:0]   o_entries_used
);

    t_cmd w_cmd;
    t_sts w_sts;

    lkvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    lkvt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_read_value   (o_read_value),
        .o_entries_used (o_entries_used)
    );

endmodule
